@@ design/epc_pkg.sv @@
// Shared constants, types and the quarter-wave gain table for the crossfader.
// Depends on nothing; used by epc_mix and equal_power_engine_crossfader.
package epc_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int GAIN_TABLE_DEPTH = 256;

  localparam int MODE_W      = 2;
  localparam int REQ_W       = 3;
  localparam int NUM_ENGINES = 4;
  localparam int OP_W        = 2;
  localparam int GAIN_W      = 17;   // Q1.16, holds 0..65536
  localparam int FRAC_BITS   = 16;
  localparam int GIDX_W      = $clog2(GAIN_TABLE_DEPTH + 1);

  localparam logic [GAIN_W-1:0] ONE_Q16    = GAIN_W'(65536);
  localparam logic [GAIN_W-1:0] STEP_RESET = GAIN_W'(91);
  localparam logic [63:0]       HALF_PI_Q30 = 64'd1686629713;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 2'd2;

  // input tdata layout, lowest bit first
  localparam int IN_MODE_LSB   = 0;
  localparam int IN_A_LSB      = IN_MODE_LSB + REQ_W;
  localparam int IN_FS_BIT     = IN_A_LSB + SAMPLE_BITS;
  localparam int IN_FE_BIT     = IN_FS_BIT + 1;
  localparam int IN_B_LSB      = IN_FE_BIT + 1;
  localparam int IN_SS_BIT     = IN_B_LSB + SAMPLE_BITS;
  localparam int IN_FIELDS_W   = IN_SS_BIT + 1;
  localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_FIELDS_W  = SAMPLE_BITS + 4 + 2 * MODE_W + NUM_ENGINES - 1;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [MODE_W-1:0] sel;
    logic [MODE_W-1:0] outg;
    logic [MODE_W-1:0] dest;
    logic [GAIN_W-1:0] prog;
    logic              run;
    logic [MODE_W-1:0] pend;
    logic              pend_v;
  } xf_state_t;

  typedef struct packed {
    xf_state_t              st;
    logic [NUM_ENGINES-1:0] rst;
  } req_res_t;

  typedef struct packed {
    logic                   slp;
    logic                   ent;
    logic [MODE_W-1:0]      first;
    logic [MODE_W-1:0]      second;
    logic                   fading;
    logic [NUM_ENGINES-1:0] resets;
  } side_t;

  typedef logic [GAIN_W-1:0] gain_tab_t [0:GAIN_TABLE_DEPTH];

  // sin(x), x in Q30 on [0, pi/2], Taylor series, Q1.16 rounded
  function automatic logic [GAIN_W-1:0] sine_q16(input logic [63:0] x);
    logic [63:0]    x2;
    logic [63:0]    term;
    longint         sum;
    longint         r;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) sum = sum - longint'(term);
      else              sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    r = (sum + 8192) / 16384;
    if (r > 65536) r = 65536;
    return GAIN_W'(r);
  endfunction

  function automatic gain_tab_t build_gain_table();
    gain_tab_t t;
    for (int i = 0; i <= GAIN_TABLE_DEPTH; i++) begin
      t[i] = sine_q16((64'(i) * HALF_PI_Q30) / GAIN_TABLE_DEPTH);
    end
    return t;
  endfunction

  localparam gain_tab_t GAIN_TABLE = build_gain_table();

endpackage

@@ design/equal_power_engine_crossfader.sv @@
// Top level of the equal-power crossfader between four sound engines.
// Depends on epc_pkg and epc_mix.
//
// Usage:
//   in_*  : one item per transfer. in_tuser carries the opcode (tick,
//           mode request, stop all motion); in_tdata the requested mode,
//           both engine samples and their sleep flags.
//   out_* : exactly one result per input item, in order: mixed sample,
//           sleep flags, the engines to feed on the next tick, the fading
//           flag and the engines whose motion is reset now.
//   cfg_* : fade step per tick (Q1.16); write only while idle.
// The result passes through three register stages: the input stage
// (routing state updated at the accept edge), a product stage and a
// round/saturate stage of the mix datapath. Throughput is one item per
// cycle; the whole pipeline advances whenever the output register is
// empty or its result is taken, so in_tready drops only while a result
// waits on a low out_tready.
// Reset clears routing to engine 0, no fade, empty queue, step 91, and
// empties the pipeline.
module equal_power_engine_crossfader import epc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // lsb first: requested_mode, first_sample, first_sleeping,
  // first_entered_sleep, second_sample, second_sleeping, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // lsb first: mixed_sample, sleeping, entered_sleep, first_engine,
  // second_engine, fading, reset_engines, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [GAIN_W-1:0]      cfg_wr_data
);

  localparam int IDX_PROD_W = GAIN_W + GIDX_W + 1;

  logic                          adv;
  logic                          in_xfer;
  logic [GAIN_W-1:0]             fade_step_r;
  logic [GAIN_W-1:0]             step_eff;
  xf_state_t                     st_r, st_nxt;

  logic [OP_W-1:0]               op;
  logic [MODE_W-1:0]             req_mode;
  logic signed [SAMPLE_BITS-1:0] in_a, in_b;

  logic [GAIN_W-1:0]             t_clamp;
  logic [IDX_PROD_W-1:0]         idx_full;
  logic [GIDX_W-1:0]             sin_idx, cos_idx;
  logic [GAIN_W:0]               prog_sum;

  logic signed [SAMPLE_BITS-1:0] a_nxt, b_nxt;
  logic [GAIN_W-1:0]             gc_nxt, gs_nxt;
  side_t                         side_nxt;
  req_res_t                      rr;

  logic signed [SAMPLE_BITS-1:0] s1_a_r, s1_b_r;
  logic [GAIN_W-1:0]             s1_gc_r, s1_gs_r;
  side_t                         s1_side_r, s2_side_r, out_side_r;
  logic                          s1_v_r, s2_v_r, out_v_r;
  logic signed [SAMPLE_BITS-1:0] mix_sample;

  function automatic req_res_t apply_request(input xf_state_t s,
                                             input logic [MODE_W-1:0] m);
    req_res_t r;
    r.st  = s;
    r.rst = '0;
    if (s.run) begin
      if (m == s.dest) begin
        r.st.sel    = m;
        r.st.pend_v = 1'b0;
      end else if (m == s.outg) begin
        // reverse the running fade
        r.st.outg   = s.dest;
        r.st.dest   = s.outg;
        r.st.prog   = ONE_Q16 - s.prog;
        r.st.sel    = m;
        r.st.pend_v = 1'b0;
      end else begin
        r.st.pend   = m;
        r.st.pend_v = 1'b1;
      end
    end else if (m != s.sel) begin
      r.st.outg = s.sel;
      r.st.dest = m;
      r.st.sel  = m;
      r.st.prog = '0;
      r.st.run  = 1'b1;
      r.rst     = NUM_ENGINES'(1) << m;
    end
    return r;
  endfunction

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;
  assign in_xfer   = in_tvalid && adv;

  assign op       = in_tuser;
  assign req_mode = in_tdata[IN_MODE_LSB + MODE_W] ? '0 : in_tdata[IN_MODE_LSB +: MODE_W];
  assign in_a     = in_tdata[IN_A_LSB +: SAMPLE_BITS];
  assign in_b     = in_tdata[IN_B_LSB +: SAMPLE_BITS];

  assign step_eff = (fade_step_r == '0) ? GAIN_W'(1) : fade_step_r;

  // gain table index from the progress before this tick
  assign t_clamp  = (st_r.prog > ONE_Q16) ? ONE_Q16 : st_r.prog;
  assign idx_full = (IDX_PROD_W'(t_clamp) * IDX_PROD_W'(GAIN_TABLE_DEPTH)
                     + IDX_PROD_W'(32768)) >> FRAC_BITS;
  assign sin_idx  = (idx_full > IDX_PROD_W'(GAIN_TABLE_DEPTH)) ? GIDX_W'(GAIN_TABLE_DEPTH)
                                                               : idx_full[GIDX_W-1:0];
  assign cos_idx  = GIDX_W'(GAIN_TABLE_DEPTH) - sin_idx;
  assign prog_sum = {1'b0, st_r.prog} + {1'b0, step_eff};

  always_comb begin
    st_nxt          = st_r;
    rr              = '0;
    a_nxt           = '0;
    b_nxt           = '0;
    gc_nxt          = '0;
    gs_nxt          = '0;
    side_nxt        = '0;
    case (op)
      OP_TICK: begin
        a_nxt = in_a;
        if (!st_r.run) begin
          // unity gain passes the sample through the mixer unchanged
          gc_nxt       = ONE_Q16;
          side_nxt.slp = in_tdata[IN_FS_BIT];
          side_nxt.ent = in_tdata[IN_FE_BIT];
        end else begin
          b_nxt        = in_b;
          gc_nxt       = GAIN_TABLE[cos_idx];
          gs_nxt       = GAIN_TABLE[sin_idx];
          side_nxt.slp = in_tdata[IN_FS_BIT] & in_tdata[IN_SS_BIT];
          if (prog_sum >= {1'b0, ONE_Q16}) begin
            side_nxt.resets = NUM_ENGINES'(1) << st_r.outg;
            st_nxt.run      = 1'b0;
            st_nxt.prog     = ONE_Q16;
            side_nxt.ent    = side_nxt.slp;
            if (st_r.pend_v) begin
              st_nxt.pend_v   = 1'b0;
              rr              = apply_request(st_nxt, st_r.pend);
              st_nxt          = rr.st;
              side_nxt.resets = side_nxt.resets | rr.rst;
            end
          end else begin
            st_nxt.prog = prog_sum[GAIN_W-1:0];
          end
        end
      end
      OP_REQUEST: begin
        rr              = apply_request(st_r, req_mode);
        st_nxt          = rr.st;
        side_nxt.resets = rr.rst;
      end
      OP_STOP: begin
        side_nxt.resets = '1;
        st_nxt.run      = 1'b0;
        st_nxt.pend_v   = 1'b0;
        st_nxt.prog     = ONE_Q16;
      end
      default: ;
    endcase
    side_nxt.fading = st_nxt.run;
    side_nxt.first  = st_nxt.run ? st_nxt.outg : st_nxt.sel;
    side_nxt.second = st_nxt.run ? st_nxt.dest : st_nxt.sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r <= STEP_RESET;
      st_r.sel    <= '0;
      st_r.outg   <= '0;
      st_r.dest   <= '0;
      st_r.prog   <= ONE_Q16;
      st_r.run    <= 1'b0;
      st_r.pend   <= '0;
      st_r.pend_v <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) fade_step_r <= cfg_wr_data;
      if (in_xfer)   st_r        <= st_nxt;
      if (adv) begin
        s1_v_r  <= in_xfer;
        s2_v_r  <= s1_v_r;
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a_r     <= a_nxt;
      s1_b_r     <= b_nxt;
      s1_gc_r    <= gc_nxt;
      s1_gs_r    <= gs_nxt;
      s1_side_r  <= side_nxt;
      s2_side_r  <= s1_side_r;
      out_side_r <= s2_side_r;
    end
  end

  epc_mix u_mix (
    .clk        (clk),
    .en         (adv),
    .a_sample   (s1_a_r),
    .b_sample   (s1_b_r),
    .cos_gain   (s1_gc_r),
    .sin_gain   (s1_gs_r),
    .mix_sample (mix_sample)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_TDATA_W'({out_side_r.resets, out_side_r.fading,
                                    out_side_r.second, out_side_r.first,
                                    out_side_r.ent, out_side_r.slp, mix_sample});

  // a running fade always goes between two different engines
  a_fade_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run |-> (st_r.outg != st_r.dest))
    else $error("fade outgoing and destination engines match");

  // the selected mode follows the fade destination
  a_sel_is_dest: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.run |-> (st_r.sel == st_r.dest))
    else $error("selected mode differs from fade destination");

  // the queue only holds a mode while a fade runs
  a_queue_needs_fade: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pend_v |-> st_r.run)
    else $error("queued mode without a running fade");

  a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.prog <= ONE_Q16)
    else $error("fade progress above one");

endmodule

@@ design/epc_mix.sv @@
// Two-stage gain mix: products, then rounded sum with saturation.
// Depends on epc_pkg for sample and gain widths.
module epc_mix import epc_pkg::*; (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] a_sample,
  input  logic signed [SAMPLE_BITS-1:0] b_sample,
  input  logic        [GAIN_W-1:0]      cos_gain,
  input  logic        [GAIN_W-1:0]      sin_gain,
  output logic signed [SAMPLE_BITS-1:0] mix_sample
);

  localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0]      prod_a_r, prod_b_r;
  logic signed [PROD_W-1:0]      prod_a_nxt, prod_b_nxt;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] mix_nxt;
  logic signed [SAMPLE_BITS-1:0] mix_r;

  assign prod_a_nxt = a_sample * $signed({1'b0, cos_gain});
  assign prod_b_nxt = b_sample * $signed({1'b0, sin_gain});

  // arithmetic shift gives floor division
  assign sum     = SUM_W'(prod_a_r) + SUM_W'(prod_b_r) + HALF;
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > SAT_MAX)      mix_nxt = SAT_MAX[SAMPLE_BITS-1:0];
    else if (shifted < SAT_MIN) mix_nxt = SAT_MIN[SAMPLE_BITS-1:0];
    else                        mix_nxt = shifted[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= prod_a_nxt;
      prod_b_r <= prod_b_nxt;
      mix_r    <= mix_nxt;
    end
  end

  assign mix_sample = mix_r;

endmodule

@@ tb/equal_power_engine_crossfader_tb.sv @@
// Self-checking bench for the four-engine equal-power crossfader.
// Needs epc_pkg and the equal_power_engine_crossfader RTL; runs directed
// routing/fade cases, then random traffic under several fade steps.
module equal_power_engine_crossfader_tb import epc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PER_STEP = 140;
  localparam int UNITY           = 65536;
  localparam int MAX_PRINTED     = 200;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // result tdata bit positions
  localparam int O_SLP    = SAMPLE_BITS;
  localparam int O_ENT    = SAMPLE_BITS + 1;
  localparam int O_FIRST  = SAMPLE_BITS + 2;
  localparam int O_SECOND = O_FIRST + MODE_W;
  localparam int O_FADE   = O_SECOND + MODE_W;
  localparam int O_RST    = O_FADE + 1;

  typedef longint unsigned u64_t;
  typedef int unsigned     u32_t;

  typedef struct {
    logic [OP_W-1:0]               op;
    logic [REQ_W-1:0]              req;
    logic signed [SAMPLE_BITS-1:0] a;
    logic                          a_sleep;
    logic                          a_entered;
    logic signed [SAMPLE_BITS-1:0] b;
    logic                          b_sleep;
  } xfade_item_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] mix;
    logic                          sleeping;
    logic                          entered;
    logic [MODE_W-1:0]             first_eng;
    logic [MODE_W-1:0]             second_eng;
    logic                          fading;
    logic [NUM_ENGINES-1:0]        resets;
  } mix_result_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic [OP_W-1:0]        in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en   = 1'b0;
  logic [GAIN_W-1:0]      cfg_wr_data = '0;

  equal_power_engine_crossfader dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  xfade_item_t feed_q[$];
  mix_result_t expected_mix_q[$];
  logic        in_accepted = 1'b0;
  bit          calm        = 1'b0;
  int          error_count = 0;
  int          cycle_count = 0;

  // crossfader shadow state
  int unsigned       sine_tab [0:GAIN_TABLE_DEPTH];
  logic [MODE_W-1:0] cur_mode    = '0;
  logic [MODE_W-1:0] from_mode   = '0;
  logic [MODE_W-1:0] to_mode     = '0;
  logic [MODE_W-1:0] queued_mode = '0;
  bit                queued_v    = 1'b0;
  bit                fade_on     = 1'b0;
  int unsigned       progress    = UNITY;
  int unsigned       step_q16    = 91;

  // fixed-point Taylor series: angle in Q30 on [0, pi/2], gain in Q1.16
  function automatic int unsigned quarter_sine_q16(input longint unsigned ang);
    longint unsigned sq;
    longint unsigned t;
    longint          acc;
    longint          q;
    sq  = (ang * ang) >> 30;
    t   = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 10; n++) begin
      t = ((t * sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    q = (acc + 8192) / 16384;
    if (q > UNITY) q = UNITY;
    return u32_t'(q);
  endfunction

  function automatic logic [NUM_ENGINES-1:0] enter_mode(input logic [REQ_W-1:0] req);
    int unsigned                m;
    logic [NUM_ENGINES-1:0]     rs;
    logic [MODE_W-1:0]          tmp;
    rs = '0;
    m  = (req >= NUM_ENGINES) ? 0 : req;
    if (!fade_on && m == cur_mode) return rs;
    if (fade_on) begin
      if (m == to_mode) begin
        cur_mode = MODE_W'(m);
        queued_v = 1'b0;
      end else if (m == from_mode) begin
        // reversal: swap ends and mirror the progress
        tmp       = from_mode;
        from_mode = to_mode;
        to_mode   = tmp;
        progress  = UNITY - progress;
        cur_mode  = MODE_W'(m);
        queued_v  = 1'b0;
      end else begin
        queued_mode = MODE_W'(m);
        queued_v    = 1'b1;
      end
      return rs;
    end
    from_mode = cur_mode;
    to_mode   = MODE_W'(m);
    cur_mode  = MODE_W'(m);
    progress  = 0;
    fade_on   = 1'b1;
    rs[m]     = 1'b1;
    return rs;
  endfunction

  function automatic mix_result_t route_and_mix(input xfade_item_t it);
    mix_result_t            r;
    logic [NUM_ENGINES-1:0] rs;
    longint                 acc;
    longint                 hi;
    int unsigned            t;
    int unsigned            idx;
    r  = '{default: '0};
    rs = '0;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    case (it.op)
      OP_TICK: begin
        if (!fade_on) begin
          r.mix      = it.a;
          r.sleeping = it.a_sleep;
          r.entered  = it.a_entered;
        end else begin
          t   = (progress > UNITY) ? UNITY : progress;
          idx = (t * GAIN_TABLE_DEPTH + 32768) >> 16;
          if (idx > GAIN_TABLE_DEPTH) idx = GAIN_TABLE_DEPTH;
          acc = longint'(it.a) * longint'(sine_tab[GAIN_TABLE_DEPTH - idx])
              + longint'(it.b) * longint'(sine_tab[idx]) + 32768;
          acc = acc >>> 16;
          if (acc > hi) acc = hi;
          if (acc < -hi - 1) acc = -hi - 1;
          r.mix      = SAMPLE_BITS'(acc);
          r.sleeping = it.a_sleep & it.b_sleep;
          progress   = progress + ((step_q16 == 0) ? 1 : step_q16);
          if (progress >= UNITY) begin
            rs[from_mode] = 1'b1;
            fade_on       = 1'b0;
            progress      = UNITY;
            r.entered     = r.sleeping;
            if (queued_v) begin
              queued_v = 1'b0;
              rs       = rs | enter_mode(REQ_W'(queued_mode));
            end
          end
        end
      end
      OP_REQUEST: rs = enter_mode(it.req);
      OP_STOP: begin
        rs       = '1;
        fade_on  = 1'b0;
        queued_v = 1'b0;
        progress = UNITY;
      end
      default: ;
    endcase
    r.first_eng  = fade_on ? from_mode : cur_mode;
    r.second_eng = fade_on ? to_mode : cur_mode;
    r.fading     = fade_on;
    r.resets     = rs;
    return r;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return SMAX;
    if (r < 30) return SMIN;
    return SAMPLE_BITS'($urandom);
  endfunction

  function automatic xfade_item_t random_item();
    xfade_item_t it;
    int unsigned r;
    r = $urandom_range(99);
    it.op        = (r < 66) ? OP_TICK : (r < 94) ? OP_REQUEST : (r < 97) ? OP_STOP : OP_UNUSED;
    it.req       = REQ_W'($urandom_range(7));
    it.a         = random_sample();
    it.b         = random_sample();
    it.a_sleep   = 1'($urandom_range(1));
    it.a_entered = 1'($urandom_range(1));
    it.b_sleep   = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic xfade_item_t cmd(input logic [OP_W-1:0] op, input int unsigned m);
    xfade_item_t it;
    it     = random_item();
    it.op  = op;
    it.req = REQ_W'(m);
    return it;
  endfunction

  function automatic xfade_item_t tick(input logic signed [SAMPLE_BITS-1:0] a,
                                       input logic signed [SAMPLE_BITS-1:0] b,
                                       input logic [2:0] flags);
    xfade_item_t it;
    it           = cmd(OP_TICK, 0);
    it.a         = a;
    it.b         = b;
    it.a_sleep   = flags[0];
    it.a_entered = flags[1];
    it.b_sleep   = flags[2];
    return it;
  endfunction

  // drain everything in flight; checked at the rising edge so a pop by
  // the driver cannot slip past
  task automatic settle();
    do @(posedge clk);
    while (feed_q.size() != 0 || in_tvalid || expected_mix_q.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_step(input int unsigned v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= GAIN_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  always @(negedge clk) begin : driver
    xfade_item_t nxt;
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 19);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_accepted) begin
      if (feed_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        nxt       = feed_q.pop_front();
        in_tuser  <= nxt.op;
        in_tdata  <= IN_TDATA_W'({nxt.b_sleep, nxt.b, nxt.a_entered, nxt.a_sleep,
                                  nxt.a, nxt.req});
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    xfade_item_t seen;
    mix_result_t got;
    mix_result_t want;
    cycle_count++;
    in_accepted <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen.op        = in_tuser;
        seen.req       = in_tdata[IN_MODE_LSB +: REQ_W];
        seen.a         = in_tdata[IN_A_LSB +: SAMPLE_BITS];
        seen.a_sleep   = in_tdata[IN_FS_BIT];
        seen.a_entered = in_tdata[IN_FE_BIT];
        seen.b         = in_tdata[IN_B_LSB +: SAMPLE_BITS];
        seen.b_sleep   = in_tdata[IN_SS_BIT];
        expected_mix_q.push_back(route_and_mix(seen));
      end
      // a step written at this edge applies to later transfers
      if (cfg_wr_en) step_q16 = 32'(cfg_wr_data);
      if (out_tvalid && out_tready) begin
        got.mix        = out_tdata[SAMPLE_BITS-1:0];
        got.sleeping   = out_tdata[O_SLP];
        got.entered    = out_tdata[O_ENT];
        got.first_eng  = out_tdata[O_FIRST +: MODE_W];
        got.second_eng = out_tdata[O_SECOND +: MODE_W];
        got.fading     = out_tdata[O_FADE];
        got.resets     = out_tdata[O_RST +: NUM_ENGINES];
        if (expected_mix_q.size() == 0) begin
          report_error("result transfer with nothing expected");
        end else begin
          want = expected_mix_q.pop_front();
          check_field("mixed_sample", got.mix, want.mix);
          check_field("sleeping", got.sleeping, want.sleeping);
          check_field("entered_sleep", got.entered, want.entered);
          check_field("first_engine", got.first_eng, want.first_eng);
          check_field("second_engine", got.second_eng, want.second_eng);
          check_field("fading", got.fading, want.fading);
          check_field("reset_engines", got.resets, want.resets);
        end
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    int unsigned steps [8];
    for (int i = 0; i <= GAIN_TABLE_DEPTH; i++)
      sine_tab[i] = quarter_sine_q16((u64_t'(i) * HALF_PI_Q30) / GAIN_TABLE_DEPTH);
    steps = '{65536, 1, 0, 131071, 91, 2000, 12000, 0};
    steps[7] = $urandom_range(65536, 1);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset step: passthrough, no-op requests, start, retarget, reverse, queue
    feed_q.push_back(tick(SMAX, SMIN, 3'b011));
    feed_q.push_back(tick(SMIN, SMAX, 3'b100));
    feed_q.push_back(cmd(OP_REQUEST, 0));
    feed_q.push_back(cmd(OP_REQUEST, 4));
    feed_q.push_back(cmd(OP_REQUEST, 2));
    feed_q.push_back(tick(SMAX, SMAX, 3'b011));
    feed_q.push_back(tick(SMIN, SMIN, 3'b111));
    feed_q.push_back(cmd(OP_REQUEST, 2));
    feed_q.push_back(cmd(OP_REQUEST, 0));
    feed_q.push_back(cmd(OP_REQUEST, 3));
    feed_q.push_back(cmd(OP_REQUEST, 7));
    feed_q.push_back(cmd(OP_REQUEST, 1));
    feed_q.push_back(cmd(OP_UNUSED, 5));
    feed_q.push_back(cmd(OP_STOP, 6));
    settle();

    // fast fade: completion with a queued mode, mid-fade saturation
    write_step(30000);
    feed_q.push_back(cmd(OP_REQUEST, 3));
    feed_q.push_back(cmd(OP_REQUEST, 1));
    feed_q.push_back(tick(SMAX, SMAX, 3'b000));
    feed_q.push_back(tick(SMAX, SMAX, 3'b010));
    feed_q.push_back(tick(SMIN, SMIN, 3'b101));
    feed_q.push_back(tick(SMIN, SMAX, 3'b001));
    feed_q.push_back(tick(SMAX, SMIN, 3'b100));
    feed_q.push_back(tick(SMIN, SMIN, 3'b111));
    feed_q.push_back(cmd(OP_REQUEST, 1));
    feed_q.push_back(cmd(OP_STOP, 0));

    // each phase drains fully before the next step write
    foreach (steps[p]) begin
      settle();
      write_step(steps[p]);
      calm = (p == 6);
      repeat (RANDOM_PER_STEP) feed_q.push_back(random_item());
    end
    settle();

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
